// ===== hdl/mtd_pkg.sv =====
package mtd_pkg;

	// Buffer limit and the widths that follow from it.
	localparam int MaxLen = 20;
	localparam int CntW   = $clog2(MaxLen + 1);

	// Depth of the queue between the front and the back.
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// Characters used by the terminal protocol.
	localparam logic [7:0] CH_BS   = 8'h08;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_X    = 8'h58;

	// Kind of an input beat.
	typedef enum logic {
		CMD_RX     = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	// Kind of work handed from the front to the back.
	typedef enum logic {
		JOB_ECHO  = 1'b0,
		JOB_BURST = 1'b1
	} job_kind_t;

	typedef struct packed {
		job_kind_t       kind;
		logic [7:0]      data;
		logic [CntW-1:0] count;
		logic            led;
	} job_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ERASE,
		BK_CHAR,
		BK_LF
	} back_state_t;

	typedef struct packed {
		logic idle;
		logic pop;
	} back_status_t;

	// Morse lookup: index is a leading one over the code bits, a dash is a one.
	function automatic logic [7:0] decode_char(input logic [7:0] idx);
		logic [7:0] c;
		unique case (idx)
			8'd2:    c = 8'h65;
			8'd3:    c = 8'h74;
			8'd4:    c = 8'h69;
			8'd5:    c = 8'h61;
			8'd6:    c = 8'h6E;
			8'd7:    c = 8'h6D;
			8'd8:    c = 8'h73;
			8'd9:    c = 8'h75;
			8'd10:   c = 8'h72;
			8'd11:   c = 8'h77;
			8'd12:   c = 8'h64;
			8'd13:   c = 8'h6B;
			8'd14:   c = 8'h67;
			8'd15:   c = 8'h6F;
			8'd16:   c = 8'h68;
			8'd17:   c = 8'h76;
			8'd18:   c = 8'h66;
			8'd20:   c = 8'h6C;
			8'd22:   c = 8'h70;
			8'd23:   c = 8'h6A;
			8'd24:   c = 8'h62;
			8'd25:   c = 8'h78;
			8'd26:   c = 8'h63;
			8'd27:   c = 8'h79;
			8'd28:   c = 8'h7A;
			8'd29:   c = 8'h71;
			8'd32:   c = 8'h35;
			8'd33:   c = 8'h34;
			8'd35:   c = 8'h33;
			8'd39:   c = 8'h32;
			8'd40:   c = 8'h26;
			8'd42:   c = 8'h2B;
			8'd47:   c = 8'h31;
			8'd48:   c = 8'h36;
			8'd49:   c = 8'h3D;
			8'd50:   c = 8'h2F;
			8'd54:   c = 8'h28;
			8'd56:   c = 8'h37;
			8'd60:   c = 8'h38;
			8'd62:   c = 8'h39;
			8'd63:   c = 8'h30;
			8'd76:   c = 8'h3F;
			8'd77:   c = 8'h5F;
			8'd82:   c = 8'h22;
			8'd85:   c = 8'h2E;
			8'd90:   c = 8'h40;
			8'd94:   c = 8'h27;
			8'd97:   c = 8'h2D;
			8'd106:  c = 8'h3B;
			8'd107:  c = 8'h21;
			8'd109:  c = 8'h29;
			8'd115:  c = 8'h2C;
			8'd120:  c = 8'h3A;
			8'd128:  c = 8'h20;
			8'd129:  c = 8'h0A;
			8'd137:  c = 8'h24;
			8'd202:  c = 8'h23;
			8'd210:  c = 8'h25;
			8'd213:  c = 8'h2A;
			8'd217:  c = 8'h5E;
			8'd221:  c = 8'h7E;
			8'd229:  c = 8'h5B;
			8'd234:  c = 8'h5D;
			8'd237:  c = 8'h7B;
			8'd242:  c = 8'h7D;
			8'd245:  c = 8'h3C;
			8'd249:  c = 8'h3E;
			default: c = CH_X;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/mtd_front.sv =====
module mtd_front import mtd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       s_tuser,          // cmd
	input  logic [15:0] s_tdata,         // rx_byte [7:0], sample [15:8]
	input  logic       threshold_we,
	input  logic [7:0] threshold_wdata,
	input  logic       q_full,
	output logic       push,
	output job_t       push_job
);

	logic [7:0]      threshold_q;
	logic [6:0]      bits_q;
	logic [CntW-1:0] count_q;
	logic            bad_q;
	logic            omode_q;
	logic            led_q;

	logic            accept;
	cmd_t            cmd;
	logic [7:0]      rx_byte;
	logic [7:0]      sample;
	logic [7:0]      code_idx;
	logic [7:0]      code_char;
	logic            above;
	logic            do_burst;
	logic            do_echo;
	logic            do_store;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign cmd      = cmd_t'(s_tuser);
	assign rx_byte  = s_tdata[7:0];
	assign sample   = s_tdata[15:8];
	assign above    = sample > threshold_q;

	// Classify the beat.
	assign do_burst = accept && (cmd == CMD_SAMPLE) && above && !omode_q && (count_q != '0);
	assign do_echo  = accept && (cmd == CMD_RX) && !omode_q && (rx_byte != 8'h00);
	assign do_store = do_echo && (count_q < CntW'(MaxLen));

	// Character for the stored symbols; only lengths one to seven are in the table.
	assign code_idx = (8'd1 << count_q[2:0]) | {1'b0, bits_q};
	always_comb begin
		if (bad_q || (count_q > CntW'(7))) begin
			code_char = CH_X;
		end else begin
			code_char = decode_char(code_idx);
		end
	end

	// Work for the back end.
	assign push = do_burst || do_echo;
	always_comb begin
		push_job.kind  = do_burst ? JOB_BURST : JOB_ECHO;
		push_job.data  = do_burst ? code_char : rx_byte;
		push_job.count = count_q;
		push_job.led   = do_burst ? 1'b0 : led_q;
	end

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 8'd128;
		end else if (threshold_we) begin
			threshold_q <= threshold_wdata;
		end
	end

	// Mode and symbol buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= '0;
			count_q <= '0;
			bad_q   <= 1'b0;
			omode_q <= 1'b0;
			led_q   <= 1'b0;
		end else if (accept) begin
			if (cmd == CMD_SAMPLE) begin
				led_q   <= !above;
				omode_q <= above;
				if (do_burst) begin
					bits_q  <= '0;
					count_q <= '0;
					bad_q   <= 1'b0;
				end
			end else if (do_store) begin
				if ((rx_byte != CH_ZERO) && (rx_byte != CH_ONE)) begin
					bad_q <= 1'b1;
				end
				if (count_q < CntW'(7)) begin
					bits_q <= {bits_q[5:0], rx_byte == CH_ONE};
				end
				count_q <= count_q + CntW'(1);
			end
		end
	end

endmodule

// ===== hdl/mtd_queue.sv =====
module mtd_queue import mtd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	output logic q_valid,
	output job_t q_job,
	input  logic pop
);

	job_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign full    = count_q == QCntW'(QDepth);
	assign q_valid = count_q != '0;
	assign q_job   = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCntW'(1);
			end
		end
	end

endmodule

// ===== hdl/mtd_back.sv =====
module mtd_back import mtd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  job_t         q_job,
	output back_status_t status,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   tx_byte,
	output logic         mode_led,
	output logic         m_tlast
);

	back_state_t     state_q, state_n;
	logic            valid_q, valid_n;
	logic [7:0]      tx_q, tx_n;
	logic            led_q, led_n;
	logic            last_q, last_n;
	logic [CntW-1:0] rem_q, rem_n;
	logic [1:0]      phase_q, phase_n;
	logic [7:0]      char_q, char_n;
	logic            cled_q, cled_n;
	logic            adv;
	logic            pop;

	assign adv      = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign tx_byte  = tx_q;
	assign mode_led = led_q;
	assign m_tlast  = last_q;

	assign status.idle = state_q == BK_IDLE;
	assign status.pop  = pop;

	// Next state and the next output beat.
	always_comb begin
		state_n = state_q;
		valid_n = valid_q;
		tx_n    = tx_q;
		led_n   = led_q;
		last_n  = last_q;
		rem_n   = rem_q;
		phase_n = phase_q;
		char_n  = char_q;
		cled_n  = cled_q;
		pop     = 1'b0;
		if (adv) begin
			valid_n = 1'b0;
			unique case (state_q)
				BK_IDLE: begin
					if (q_valid) begin
						pop     = 1'b1;
						valid_n = 1'b1;
						led_n   = q_job.led;
						if (q_job.kind == JOB_ECHO) begin
							tx_n   = q_job.data;
							last_n = 1'b1;
						end else begin
							tx_n    = CH_BS;
							last_n  = 1'b0;
							rem_n   = q_job.count;
							phase_n = 2'd1;
							char_n  = q_job.data;
							cled_n  = q_job.led;
							state_n = BK_ERASE;
						end
					end
				end
				BK_ERASE: begin
					valid_n = 1'b1;
					led_n   = cled_q;
					last_n  = 1'b0;
					tx_n    = (phase_q == 2'd1) ? CH_SP : CH_BS;
					if (phase_q == 2'd2) begin
						phase_n = 2'd0;
						if (rem_q == CntW'(1)) begin
							state_n = BK_CHAR;
						end else begin
							rem_n = rem_q - CntW'(1);
						end
					end else begin
						phase_n = phase_q + 2'd1;
					end
				end
				BK_CHAR: begin
					valid_n = 1'b1;
					led_n   = cled_q;
					if (char_q == CH_LF) begin
						tx_n    = CH_CR;
						last_n  = 1'b0;
						state_n = BK_LF;
					end else begin
						tx_n    = char_q;
						last_n  = 1'b1;
						state_n = BK_IDLE;
					end
				end
				BK_LF: begin
					valid_n = 1'b1;
					led_n   = cled_q;
					tx_n    = CH_LF;
					last_n  = 1'b1;
					state_n = BK_IDLE;
				end
				default: begin
					state_n = BK_IDLE;
				end
			endcase
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid_q <= 1'b0;
			rem_q   <= '0;
			phase_q <= 2'd0;
		end else begin
			state_q <= state_n;
			valid_q <= valid_n;
			rem_q   <= rem_n;
			phase_q <= phase_n;
		end
	end

	// Output beat and burst payload.
	always_ff @(posedge clk) begin
		tx_q   <= tx_n;
		led_q  <= led_n;
		last_q <= last_n;
		char_q <= char_n;
		cled_q <= cled_n;
	end

endmodule

// ===== hdl/morse_terminal_decoder_unit.sv =====
// Morse terminal decoder.
// Input stream: s_tuser selects the beat kind (0 = terminal byte in s_tdata[7:0],
// 1 = converter sample in s_tdata[15:8]). Output stream: m_tdata[7:0] is the byte
// for the terminal, m_tdata[8] the mode LED, and m_tlast marks the final byte
// caused by one input beat. threshold_we writes the mode threshold; write it only
// while the block is idle.
// An echoed byte passes through the work queue and the output register. A sample
// that ends a Morse character sends three erase bytes per stored symbol and then
// the character (two bytes for a newline), one byte per cycle while m_tready is high.
// Throughput: one input beat per cycle while the back end keeps up; the front end
// classifies each beat combinationally and the back end sequencer sends one byte per
// cycle while m_tready is high, so a long erase burst fills the four-entry work
// queue and then holds off s_tready until entries drain.
// Reset clears the buffer, selects input mode with the LED off, and sets the
// threshold to 128. When the receiver stalls, the output register holds its beat,
// the back end waits, and the queue fills before the input side stalls.
module morse_terminal_decoder_unit import mtd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,          // cmd
	input  logic [15:0] s_tdata,          // rx_byte [7:0], sample [15:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,          // tx_byte [7:0], mode_led [8], zero [15:9]
	output logic        m_tlast,
	input  logic        threshold_we,
	input  logic [7:0]  threshold_wdata
);

	logic         push;
	job_t         push_job;
	logic         q_full;
	logic         q_valid;
	job_t         q_job;
	back_status_t bk_status;
	logic [7:0]   tx_byte;
	logic         mode_led;

	// Front end: handshake, mode tracking and symbol buffer.
	mtd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tuser         (s_tuser),
		.s_tdata         (s_tdata),
		.threshold_we    (threshold_we),
		.threshold_wdata (threshold_wdata),
		.q_full          (q_full),
		.push            (push),
		.push_job        (push_job)
	);

	// Work queue between the two halves.
	mtd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_job    (q_job),
		.pop      (bk_status.pop)
	);

	// Back end: byte sequencer and output register.
	mtd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (q_job),
		.status   (bk_status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.tx_byte  (tx_byte),
		.mode_led (mode_led),
		.m_tlast  (m_tlast)
	);

	assign m_tdata = {7'd0, mode_led, tx_byte};

	// A burst is only queued when symbols are stored.
	a_burst_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push && (push_job.kind == JOB_BURST) |-> push_job.count != '0)
		else $error("burst queued with an empty buffer");

	// An echo taken from the queue shows up as a single final beat.
	a_echo_last: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.pop && (q_job.kind == JOB_ECHO) |=> m_tvalid && m_tlast)
		else $error("echo did not produce a final beat");

	// Mid-burst the output holds a beat that is not the last.
	a_burst_open: assert property (@(posedge clk) disable iff (!arst_n)
		!bk_status.idle |-> m_tvalid && !m_tlast)
		else $error("burst in progress without a pending beat");

	// Burst bytes carry the output-mode LED value.
	a_burst_led: assert property (@(posedge clk) disable iff (!arst_n)
		!bk_status.idle |-> !m_tdata[8])
		else $error("LED set during a decode burst");

endmodule

// ===== dv/morse_terminal_decoder_unit_tb.sv =====
module morse_terminal_decoder_unit_tb;
	import mtd_pkg::*;

	// One byte sent to the terminal, as the output stream carries it.
	typedef struct packed {
		logic [7:0] tx;
		logic       led;
		logic       last;
	} tx_beat_t;

	// How a directed row is checked.
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_ONE
	} row_check_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] rx;
		logic [7:0] smp;
		row_check_t how;
		logic [7:0] tx;
		logic       led;
	} stim_row_t;

	localparam int StallLimit  = 3000;
	localparam int DrainCycles = 12;
	localparam int Phases      = 5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic        s_tuser = 1'b0;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        threshold_we = 1'b0;
	logic [7:0]  threshold_wdata = '0;

	// Predicted decoder state.
	logic [7:0] threshold_model = 8'd128;
	logic [6:0] sym_bits = '0;
	logic [4:0] sym_count = '0;
	logic       sym_bad = 1'b0;
	logic       output_mode_model = 1'b0;
	logic       led_model = 1'b0;

	tx_beat_t pending_tx [$];
	tx_beat_t want;

	int fails = 0;
	int live_items = 0;
	int accepted_items = 0;
	int tx_seen = 0;
	int decodes = 0;
	int stalled_cycles = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	// Directed items: reset state, extremes, dropped bytes, bad symbols and newline.
	stim_row_t directed [0:22] = '{
		'{CMD_RX,     CH_ZERO, 8'hA5,  CHK_ONE,   CH_ZERO, 1'b0},
		'{CMD_RX,     8'h00,   8'hFF,  CHK_NONE,  8'h00,   1'b0},
		'{CMD_RX,     CH_ONE,  8'h00,  CHK_ONE,   CH_ONE,  1'b0},
		'{CMD_SAMPLE, 8'hFF,   8'd128, CHK_NONE,  8'h00,   1'b0},
		'{CMD_SAMPLE, 8'h00,   8'd129, CHK_MODEL, 8'h00,   1'b0},
		'{CMD_RX,     CH_ZERO, 8'h00,  CHK_NONE,  8'h00,   1'b0},
		'{CMD_SAMPLE, 8'h00,   8'd255, CHK_NONE,  8'h00,   1'b0},
		'{CMD_SAMPLE, 8'h00,   8'd0,   CHK_NONE,  8'h00,   1'b0},
		'{CMD_RX,     8'hFF,   8'h00,  CHK_ONE,   8'hFF,   1'b1},
		'{CMD_SAMPLE, 8'h00,   8'd255, CHK_MODEL, 8'h00,   1'b0},
		'{CMD_SAMPLE, 8'h00,   8'd17,  CHK_NONE,  8'h00,   1'b0},
		'{CMD_RX,     CH_ZERO, 8'h3C,  CHK_ONE,   CH_ZERO, 1'b1},
		'{CMD_RX,     CH_ZERO, 8'h00,  CHK_ONE,   CH_ZERO, 1'b1},
		'{CMD_RX,     CH_ZERO, 8'hC3,  CHK_ONE,   CH_ZERO, 1'b1},
		'{CMD_RX,     CH_ZERO, 8'h00,  CHK_ONE,   CH_ZERO, 1'b1},
		'{CMD_RX,     CH_ZERO, 8'h81,  CHK_ONE,   CH_ZERO, 1'b1},
		'{CMD_RX,     CH_ZERO, 8'h00,  CHK_ONE,   CH_ZERO, 1'b1},
		'{CMD_RX,     CH_ONE,  8'h7E,  CHK_ONE,   CH_ONE,  1'b1},
		'{CMD_SAMPLE, 8'h55,   8'd200, CHK_MODEL, 8'h00,   1'b0},
		'{CMD_SAMPLE, 8'hAA,   8'd0,   CHK_NONE,  8'h00,   1'b0},
		'{CMD_RX,     8'h80,   8'h00,  CHK_ONE,   8'h80,   1'b1},
		'{CMD_SAMPLE, 8'h00,   8'd130, CHK_MODEL, 8'h00,   1'b0},
		'{CMD_SAMPLE, 8'h00,   8'd64,  CHK_NONE,  8'h00,   1'b0}
	};

	morse_terminal_decoder_unit dut (
		.clk,
		.arst_n,
		.s_tvalid,
		.s_tready,
		.s_tuser,
		.s_tdata,
		.m_tvalid,
		.m_tready,
		.m_tdata,
		.m_tlast,
		.threshold_we,
		.threshold_wdata
	);

	always #5 clk = ~clk;

	// Morse lookup keyed by a leading one over the symbol bits, dash as one.
	function automatic logic [7:0] morse_char(input logic [4:0] n, input logic [6:0] code,
			input logic bad);
		logic [7:0] key;
		logic [7:0] c;
		if (bad || n < 1 || n > 7) return CH_X;
		key = (8'd1 << n) | {1'b0, code};
		case (key)
			8'd2: c = "e";   8'd3: c = "t";   8'd4: c = "i";   8'd5: c = "a";
			8'd6: c = "n";   8'd7: c = "m";   8'd8: c = "s";   8'd9: c = "u";
			8'd10: c = "r";  8'd11: c = "w";  8'd12: c = "d";  8'd13: c = "k";
			8'd14: c = "g";  8'd15: c = "o";  8'd16: c = "h";  8'd17: c = "v";
			8'd18: c = "f";  8'd20: c = "l";  8'd22: c = "p";  8'd23: c = "j";
			8'd24: c = "b";  8'd25: c = "x";  8'd26: c = "c";  8'd27: c = "y";
			8'd28: c = "z";  8'd29: c = "q";  8'd32: c = "5";  8'd33: c = "4";
			8'd35: c = "3";  8'd39: c = "2";  8'd40: c = "&";  8'd42: c = "+";
			8'd47: c = "1";  8'd48: c = "6";  8'd49: c = "=";  8'd50: c = "/";
			8'd54: c = "(";  8'd56: c = "7";  8'd60: c = "8";  8'd62: c = "9";
			8'd63: c = "0";  8'd76: c = "?";  8'd77: c = "_";  8'd82: c = "\"";
			8'd85: c = ".";  8'd90: c = "@";  8'd94: c = "'";  8'd97: c = "-";
			8'd106: c = ";"; 8'd107: c = "!"; 8'd109: c = ")"; 8'd115: c = ",";
			8'd120: c = ":"; 8'd128: c = " "; 8'd129: c = CH_LF; 8'd137: c = "$";
			8'd202: c = "#"; 8'd210: c = "%"; 8'd213: c = "*"; 8'd217: c = "^";
			8'd221: c = "~"; 8'd229: c = "["; 8'd234: c = "]"; 8'd237: c = "{";
			8'd242: c = "}"; 8'd245: c = "<"; 8'd249: c = ">";
			default: c = CH_X;
		endcase
		return c;
	endfunction

	// Advance the predicted state by one input beat and queue the terminal bytes it causes.
	task automatic predict_terminal_bytes(input cmd_t kind, input logic [7:0] rx,
			input logic [7:0] smp, input bit record);
		tx_beat_t burst [$];
		logic [7:0] ch;
		if (kind == CMD_SAMPLE) begin
			live_items++;
			if (smp <= threshold_model) begin
				led_model = 1'b1;
				output_mode_model = 1'b0;
			end else begin
				led_model = 1'b0;
				if (!output_mode_model && sym_count > 0) begin
					ch = morse_char(sym_count, sym_bits, sym_bad);
					for (int i = 0; i < sym_count; i++) begin
						burst.push_back('{CH_BS, led_model, 1'b0});
						burst.push_back('{CH_SP, led_model, 1'b0});
						burst.push_back('{CH_BS, led_model, 1'b0});
					end
					if (ch == CH_LF) begin
						burst.push_back('{CH_CR, led_model, 1'b0});
						burst.push_back('{CH_LF, led_model, 1'b0});
					end else begin
						burst.push_back('{ch, led_model, 1'b0});
					end
					sym_bits = '0;
					sym_count = '0;
					sym_bad = 1'b0;
					decodes++;
				end
				output_mode_model = 1'b1;
			end
		end else if (!output_mode_model && rx != 8'h00) begin
			// Echo the byte; once the buffer is full it is echoed but not stored.
			live_items++;
			burst.push_back('{rx, led_model, 1'b0});
			if (sym_count < MaxLen) begin
				if (rx != CH_ZERO && rx != CH_ONE) sym_bad = 1'b1;
				if (sym_count < 7) sym_bits = {sym_bits[5:0], rx == CH_ONE};
				sym_count++;
			end
		end
		if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
		if (record) begin
			foreach (burst[i]) pending_tx.push_back(burst[i]);
		end
	endtask

	// Offer one input beat, with random idle cycles ahead of it, and wait for its acceptance.
	task automatic send_item(input cmd_t kind, input logic [7:0] rx, input logic [7:0] smp,
			input bit record);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {smp, rx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		accepted_items++;
		predict_terminal_bytes(kind, rx, smp, record);
	endtask

	// Wait until every predicted byte has arrived and the pipeline has gone quiet.
	task automatic settle();
		while (pending_tx.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Random part: mostly whole characters framed by a low and a high sample, some noise.
	task automatic run_random(input int target);
		int start;
		int len;
		logic [7:0] sym;
		start = live_items;
		while (live_items - start < target) begin
			if ($urandom_range(99) < 75) begin
				send_item(CMD_SAMPLE, 8'($urandom), 8'($urandom_range(threshold_model)), 1'b1);
				if ($urandom_range(9) == 0) len = $urandom_range(MaxLen + 4, 8);
				else len = $urandom_range(7, 1);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(29) == 0) sym = 8'($urandom_range(255, 1));
					else sym = $urandom_range(1) ? CH_ONE : CH_ZERO;
					send_item(CMD_RX, sym, 8'($urandom), 1'b1);
				end
				if (threshold_model == 8'd255)
					send_item(CMD_SAMPLE, 8'($urandom), 8'd255, 1'b1);
				else
					send_item(CMD_SAMPLE, 8'($urandom),
						8'($urandom_range(255, threshold_model + 1)), 1'b1);
			end else begin
				send_item($urandom_range(1) ? CMD_SAMPLE : CMD_RX,
					($urandom_range(7) == 0) ? 8'h00 : 8'($urandom), 8'($urandom), 1'b1);
			end
		end
	endtask

	// Receiver side: random back-pressure at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Compare every output beat against the oldest predicted byte.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tx_seen++;
			if (pending_tx.size() == 0) begin
				$error("output beat with nothing pending: tx_byte 0x%h", m_tdata[7:0]);
				fails++;
			end else begin
				want = pending_tx.pop_front();
				if (m_tdata[7:0] !== want.tx) begin
					$error("tx_byte: expected 0x%h, got 0x%h", want.tx, m_tdata[7:0]);
					fails++;
				end
				if (m_tdata[8] !== want.led) begin
					$error("mode_led: expected %b, got %b", want.led, m_tdata[8]);
					fails++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %b, got %b", want.last, m_tlast);
					fails++;
				end
				if (m_tdata[15:9] !== '0) begin
					$error("tdata padding: expected 0x00, got 0x%h", m_tdata[15:9]);
					fails++;
				end
			end
		end
	end

	// Watchdog: end the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stalled_cycles <= 0;
		else stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= StallLimit) begin
			$display("Timeout: no beat moved for %0d cycles", StallLimit);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int src_plan [Phases];
		int sink_plan [Phases];
		logic [7:0] thr_plan [Phases];
		src_plan  = '{0, 72, 0, 25, 0};
		sink_plan = '{0, 0, 72, 25, 0};
		thr_plan  = '{8'd0, 8'd255, 8'($urandom_range(254, 1)), 8'd128, 8'($urandom)};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows run with the threshold at its reset value.
		foreach (directed[i]) begin
			send_item(directed[i].cmd, directed[i].rx, directed[i].smp,
				directed[i].how == CHK_MODEL);
			if (directed[i].how == CHK_ONE)
				pending_tx.push_back('{directed[i].tx, directed[i].led, 1'b1});
		end
		s_tvalid <= 1'b0;

		// Random phases, each with its own threshold and flow-control pattern.
		for (int p = 0; p < Phases; p++) begin
			settle();
			src_idle_pct = src_plan[p];
			sink_stall_pct = sink_plan[p];
			threshold_we <= 1'b1;
			threshold_wdata <= thr_plan[p];
			@(posedge clk);
			threshold_we <= 1'b0;
			threshold_model = thr_plan[p];
			run_random(43);
			s_tvalid <= 1'b0;
		end
		settle();

		$display("Sent %0d input beats (%0d not dropped) over %0d thresholds and idle patterns.",
			accepted_items, live_items, Phases + 1);
		$display("Checked %0d terminal bytes, including %0d decode bursts.", tx_seen, decodes);
		if (fails == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule
